// ===== hdl/quadtree_key_from_box_defines.svh =====
// Assertion macros shared by the quadtree key block's checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef QUADTREE_KEY_FROM_BOX_DEFINES_SVH
`define QUADTREE_KEY_FROM_BOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QTK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadtree key check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QTK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadtree key check failed");

`endif

// ===== hdl/qtkey_pkg.sv =====
// Shared types and constants for the quadtree tile key block.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
`default_nettype none

package qtkey_pkg;

    localparam int COORD_W   = 32;
    localparam int BF_W      = 31;
    localparam int LVL_W     = 5;
    localparam int KEY_W     = 63;
    localparam int KEY_TOP   = 61;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 64;

    localparam logic [LVL_W-1:0] LEVEL_CAP       = 5'd30;
    localparam logic [LVL_W-1:0] MAX_LEVEL_RESET = 5'd18;
    localparam logic [BF_W-1:0]  BF_RESET        = 31'd53687091;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUFFER_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEVEL     = 1'b1;

    // Quadrant codes.
    localparam logic [1:0] QUAD_LX_HY = 2'd0;
    localparam logic [1:0] QUAD_HX_HY = 2'd1;
    localparam logic [1:0] QUAD_LX_LY = 2'd2;
    localparam logic [1:0] QUAD_HX_LY = 2'd3;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             emit;
        logic [LVL_W-1:0] lvl;
    } qtkey_cmd_t;

    typedef struct packed {
        logic fits;
    } qtkey_sts_t;

endpackage

`default_nettype wire

// ===== hdl/quadtree_key_from_box.sv =====
// Each box descends n levels, n from 0 to min(max_level, 30): it is loaded into
// the box registers and stepped once per level; the key then enters the output register.
// The single quadrant-select unit descends one level per cycle; a new box is taken
// only after the last key has entered the output register. A finished key waits there.
// Reset: synchronous, active low; control and config registers reset, output empties.
`default_nettype none

module quadtree_key_from_box #(
    parameter int COORD_FRAC_BITS = 30
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Box input channel. s_tdata from bit 0: min_x, min_y, max_x, max_y.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [qtkey_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result channel. m_tdata from bit 0: tile_key, one zero pad bit.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [qtkey_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write port.
    input  wire logic                             cfg_wr_en,
    input  wire logic [qtkey_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qtkey_pkg::BF_W-1:0]       cfg_wdata
);
    import qtkey_pkg::*;

    logic [BF_W-1:0]  buffer_margin_reg;
    logic [LVL_W-1:0] max_level_reg;
    logic [KEY_W-1:0] tile_key;
    qtkey_cmd_t       cmd;
    qtkey_sts_t       sts;

    // Configuration registers. Writes must be made only while the block is idle
    // (the block itself does not enforce this), so both units read them live.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_margin_reg <= BF_RESET;
            max_level_reg     <= MAX_LEVEL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_BUFFER_MARGIN: buffer_margin_reg <= cfg_wdata;
                CFG_IDX_MAX_LEVEL:     max_level_reg     <= cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // The controller takes one box, steps the datapath once per level while a
    // quadrant fits and the limit allows, and then moves the key into the
    // output register as soon as that register is free.
    qtkey_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .max_level (max_level_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the box in exact fixed point and accumulates the key.
    qtkey_dp #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .min_x         (s_tdata[COORD_W-1:0]),
        .min_y         (s_tdata[2*COORD_W-1:COORD_W]),
        .max_x         (s_tdata[3*COORD_W-1:2*COORD_W]),
        .max_y         (s_tdata[4*COORD_W-1:3*COORD_W]),
        .buffer_margin (buffer_margin_reg),
        .cmd           (cmd),
        .sts           (sts),
        .tile_key      (tile_key)
    );

    assign m_tdata = {1'b0, tile_key};

endmodule

`default_nettype wire

// ===== hdl/qtkey_ctrl.sv =====
// Controller for the quadtree tile key block: accepts boxes, counts levels,
// and hands finished keys to the output register. Depends on qtkey_pkg.
`default_nettype none

module qtkey_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [qtkey_pkg::LVL_W-1:0] max_level,
    input  wire qtkey_pkg::qtkey_sts_t     sts,
    output qtkey_pkg::qtkey_cmd_t          cmd
);
    import qtkey_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [LVL_W-1:0] limit;
    logic             out_free;

    assign limit    = (max_level > LEVEL_CAP) ? LEVEL_CAP : max_level;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.lvl       = lvl_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    lvl_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.fits && (lvl_reg < limit)) begin
                    cmd.step = 1'b1;
                    lvl_next = lvl_reg + 1'b1;
                end else if (out_free) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lvl_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lvl_reg      <= lvl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qtkey_dp.sv =====
// Datapath for the quadtree tile key block: box registers, quadrant pick,
// one-level transform, key accumulator and output register. Depends on qtkey_pkg.
`default_nettype none

module qtkey_dp #(
    parameter int COORD_FRAC_BITS = 30
) (
    input  wire logic                         aclk,
    input  wire logic [qtkey_pkg::COORD_W-1:0] min_x,
    input  wire logic [qtkey_pkg::COORD_W-1:0] min_y,
    input  wire logic [qtkey_pkg::COORD_W-1:0] max_x,
    input  wire logic [qtkey_pkg::COORD_W-1:0] max_y,
    input  wire logic [qtkey_pkg::BF_W-1:0]    buffer_margin,
    input  wire qtkey_pkg::qtkey_cmd_t         cmd,
    output qtkey_pkg::qtkey_sts_t              sts,
    output logic [qtkey_pkg::KEY_W-1:0]        tile_key
);
    import qtkey_pkg::*;

    // The range check bounds a corner on one side only, so a corner of an
    // inverted box can gain a bit at every level. Twice the input width leaves
    // room for the growth over thirty levels of any raw input.
    localparam int CW  = 2 * COORD_W;
    localparam int SHW = 6;

    logic signed [CW-1:0] lx_reg, ly_reg, hx_reg, hy_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     tile_key_reg;

    logic signed [CW-1:0] one_s, bf_s, lim_s, nlim_s, nbf_s;
    logic [CW-1:0]        alx, aly, ahx, ahy;
    logic                 in_range, xlo, xhi, ylo, yhi;
    logic                 found;
    logic [1:0]           quad;
    logic                 left, lower;
    logic [SHW-1:0]       shamt;
    logic [KEY_W-1:0]     key_add;

    function automatic logic [CW-1:0] absv(input logic signed [CW-1:0] v);
        absv = (v < 0) ? CW'(-v) : CW'(v);
    endfunction

    assign one_s  = CW'(1) <<< COORD_FRAC_BITS;
    assign bf_s   = signed'({{(CW - BF_W){1'b0}}, buffer_margin});
    assign lim_s  = one_s + bf_s;
    assign nlim_s = -lim_s;
    assign nbf_s  = -bf_s;

    assign alx = absv(lx_reg);
    assign aly = absv(ly_reg);
    assign ahx = absv(hx_reg);
    assign ahy = absv(hy_reg);

    assign in_range = !(lx_reg < nlim_s || ly_reg < nlim_s ||
                        hx_reg > lim_s  || hy_reg > lim_s);

    assign xlo = (hx_reg < bf_s)  && (ahx < alx);
    assign xhi = (lx_reg > nbf_s) && (ahx >= alx);
    assign yhi = (ly_reg > nbf_s) && (ahy >= aly);
    assign ylo = (hy_reg < bf_s)  && (ahy < aly);

    // Strict containment first, then the buffered rules.
    always_comb begin
        found = in_range;
        quad  = QUAD_LX_HY;
        if (hx_reg <= 0 && ly_reg >= 0)      quad = QUAD_LX_HY;
        else if (lx_reg >= 0 && ly_reg >= 0) quad = QUAD_HX_HY;
        else if (hx_reg <= 0 && hy_reg <= 0) quad = QUAD_LX_LY;
        else if (lx_reg >= 0 && hy_reg <= 0) quad = QUAD_HX_LY;
        else if (xlo && yhi)                 quad = QUAD_LX_HY;
        else if (xhi && yhi)                 quad = QUAD_HX_HY;
        else if (xlo && ylo)                 quad = QUAD_LX_LY;
        else if (xhi && ylo)                 quad = QUAD_HX_LY;
        else                                 found = 1'b0;
    end

    assign sts.fits = found;

    assign left  = (quad == QUAD_LX_HY) || (quad == QUAD_LX_LY);
    assign lower = (quad == QUAD_LX_LY) || (quad == QUAD_HX_LY);

    // Quadrant lands at bit 61 - 2*level; the level count adds one below it.
    assign shamt   = SHW'(KEY_TOP) - SHW'({cmd.lvl, 1'b0});
    assign key_add = (KEY_W'(quad) << shamt) | KEY_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lx_reg  <= CW'(signed'(min_x));
            ly_reg  <= CW'(signed'(min_y));
            hx_reg  <= CW'(signed'(max_x));
            hy_reg  <= CW'(signed'(max_y));
            key_reg <= '0;
        end else if (cmd.step) begin
            // Shift by a half toward the chosen quadrant and double.
            lx_reg  <= left  ? (lx_reg <<< 1) + one_s : (lx_reg <<< 1) - one_s;
            hx_reg  <= left  ? (hx_reg <<< 1) + one_s : (hx_reg <<< 1) - one_s;
            ly_reg  <= lower ? (ly_reg <<< 1) + one_s : (ly_reg <<< 1) - one_s;
            hy_reg  <= lower ? (hy_reg <<< 1) + one_s : (hy_reg <<< 1) - one_s;
            key_reg <= key_reg + key_add;
        end
        if (cmd.emit) begin
            tile_key_reg <= key_reg;
        end
    end

    assign tile_key = tile_key_reg;

endmodule

`default_nettype wire

// ===== hdl/qtkey_checker.sv =====
// Port-level checks for the quadtree tile key block, bound to its top level.
// Depends on qtkey_pkg and quadtree_key_from_box_defines.svh.
`default_nettype none
`include "quadtree_key_from_box_defines.svh"

module qtkey_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [qtkey_pkg::M_TDATA_W-1:0] m_tdata
);

    // After a box is taken the block is busy and stops taking boxes.
    `QTK_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A key never appears in the cycle right after its box was taken.
    `QTK_ASSERT_NXT(a_no_instant_out, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))

    // Handing a key to the output frees the input side at once.
    `QTK_ASSERT_IMP(a_ready_on_out, aclk, aresetn, $rose(m_tvalid), s_tready)

    // A stalled result holds its value.
    `QTK_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The pad bit above the key stays clear.
    `QTK_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, !m_tdata[qtkey_pkg::M_TDATA_W-1])

endmodule

bind quadtree_key_from_box qtkey_checker u_qtkey_checker (.*);

`default_nettype wire
